>>> design/stereo_point_projection_defines.svh
// Assertion macros for the stereo point projection block.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef STEREO_POINT_PROJECTION_DEFINES_SVH
`define STEREO_POINT_PROJECTION_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define SPP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequence must hold at the delay given by dly after the antecedent.
`define SPP_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) else $error(msg);

`endif

>>> design/spp_pkg.sv
// Package for the stereo point projection block.
// Holds field widths, the register map size and the parameter defaults; no dependencies.
`timescale 1ns / 1ps

package spp_pkg;

	localparam int PT_W       = 20;
	localparam int COEF_W     = 21;
	localparam int REG_W      = 63;
	localparam int NUM_REGS   = 8;
	localparam int IDX_W      = 4;
	localparam int FRAC_BITS  = 6;
	localparam int SHIFT_Q16  = -1311;
	localparam int DEF_WIDTH  = 280;
	localparam int DEF_HEIGHT = 220;

	typedef logic [REG_W-1:0] coeff_reg_t;
	typedef logic signed [COEF_W-1:0] coef_t;

endpackage

>>> design/stereo_point_projection.sv
// Top level of the stereo point projection block: a deep pipeline of multipliers,
// row adders, a window test and a bit-per-stage divider. Depends on spp_pkg and
// stereo_point_projection_defines.svh.
`timescale 1ns / 1ps
`include "stereo_point_projection_defines.svh"

// Usage:
// A point (point_x, point_y, point_z, point_w) transfers at a rising edge where start is
// high; busy is always low, so a new point may enter every cycle.
// Coefficients are written through write_en, reg_index and write_data while no point is
// in flight; indexes beyond the eight registers are ignored.
// Each point gives one result, shown for exactly one cycle with done high, in the order
// the points entered, after the multiply, row-sum and window-test stages and the divider
// stages. NQ, the quotient width of the wider image axis, is 15 at the default
// 280 x 220 window.
// The throughput is one point per cycle: one stage multiplies, one sums rows, one folds
// signs and tests the window, and the divider then settles one quotient bit per stage.
// The receiver cannot stall; every result must be taken in its cycle.
// Reset clears the coefficient registers and all valid bits; results in flight are lost.
// When in_view is low, all coordinates are zero.
module stereo_point_projection #(
	parameter int IMAGE_WIDTH  = spp_pkg::DEF_WIDTH,
	parameter int IMAGE_HEIGHT = spp_pkg::DEF_HEIGHT
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             start,
	output logic                                             busy,
	input  logic signed [spp_pkg::PT_W-1:0]                  point_x,
	input  logic signed [spp_pkg::PT_W-1:0]                  point_y,
	input  logic signed [spp_pkg::PT_W-1:0]                  point_z,
	input  logic signed [spp_pkg::PT_W-1:0]                  point_w,
	input  logic                                             write_en,
	input  logic [spp_pkg::IDX_W-1:0]                        reg_index,
	input  logic [spp_pkg::REG_W-1:0]                        write_data,
	output logic                                             done,
	output logic                                             in_view,
	output logic [$clog2(IMAGE_WIDTH*(2**spp_pkg::FRAC_BITS))-1:0]  left_px,
	output logic [$clog2(IMAGE_HEIGHT*(2**spp_pkg::FRAC_BITS))-1:0] left_py,
	output logic [$clog2(IMAGE_WIDTH*(2**spp_pkg::FRAC_BITS))-1:0]  right_px,
	output logic [$clog2(IMAGE_HEIGHT*(2**spp_pkg::FRAC_BITS))-1:0] right_py
);
	import spp_pkg::*;

	localparam int XW   = $clog2(IMAGE_WIDTH*(2**FRAC_BITS));
	localparam int YW   = $clog2(IMAGE_HEIGHT*(2**FRAC_BITS));
	localparam int NQ   = (XW > YW) ? XW : YW;
	localparam int XP_W = PT_W + 1;
	localparam int PR_W = COEF_W + XP_W;
	localparam int SW   = PR_W + 2;
	localparam int AW   = SW + 1;
	localparam int LW   = AW + 13;
	localparam int DW   = AW + NQ;
	localparam int LAT  = NQ + 3;

	coeff_reg_t coeff_q [NUM_REGS];
	coef_t      coef_c [2][12];

	logic signed [XP_W-1:0] pt_c [2][4];
	logic                   vld_s1;
	logic signed [PR_W-1:0] prod_s1 [2][3][4];
	logic                   vld_s2;
	logic signed [SW-1:0]   row_s2 [2][3];

	// Index 0 of these arrays is stage 3; index k+1 holds divider stage k.
	logic                   vld_s3 [NQ+1];
	logic                   ok_s3  [NQ+1];
	logic [DW-1:0]          rem_s3 [NQ+1][4];
	logic [DW-1:0]          den_s3 [NQ+1][2];
	logic [NQ-1:0]          quo_s3 [NQ+1][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (write_en && (reg_index < IDX_W'(NUM_REGS))) begin
			coeff_q[reg_index[$clog2(NUM_REGS)-1:0]] <= write_data;
		end
	end

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			for (int e = 0; e < 12; e++) begin
				coef_c[v][e] = coeff_q[v*4 + e/3][COEF_W*(e%3) +: COEF_W];
			end
		end
		pt_c[0][0] = XP_W'(point_x);
		pt_c[0][1] = XP_W'(point_y);
		pt_c[0][2] = XP_W'(point_z);
		pt_c[0][3] = XP_W'(point_w);
		pt_c[1][0] = XP_W'(point_x) + XP_W'(SHIFT_Q16);
		pt_c[1][1] = XP_W'(point_y);
		pt_c[1][2] = XP_W'(point_z);
		pt_c[1][3] = XP_W'(point_w);
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int v = 0; v < 2; v++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[v][i][j] <= PR_W'(coef_c[v][4*i+j]) * PR_W'(pt_c[v][j]);
				end
				row_s2[v][i] <= SW'(prod_s1[v][i][0]) + SW'(prod_s1[v][i][1])
					+ SW'(prod_s1[v][i][2]) + SW'(prod_s1[v][i][3]);
			end
		end
	end

	logic signed [AW-1:0] xa_c [2];
	logic signed [AW-1:0] ya_c [2];
	logic signed [AW-1:0] za_c [2];
	logic                 vok_c [2];

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			if (row_s2[v][2] < 0) begin
				xa_c[v] = -AW'(row_s2[v][0]);
				ya_c[v] = -AW'(row_s2[v][1]);
				za_c[v] = -AW'(row_s2[v][2]);
			end else begin
				xa_c[v] = AW'(row_s2[v][0]);
				ya_c[v] = AW'(row_s2[v][1]);
				za_c[v] = AW'(row_s2[v][2]);
			end
			vok_c[v] = (row_s2[v][2] != '0) && !xa_c[v][AW-1] && !ya_c[v][AW-1]
				&& (LW'(unsigned'(xa_c[v])) < LW'(unsigned'(za_c[v])) * LW'(IMAGE_WIDTH))
				&& (LW'(unsigned'(ya_c[v])) < LW'(unsigned'(za_c[v])) * LW'(IMAGE_HEIGHT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3[0] <= 1'b0;
		end else begin
			vld_s3[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3[0] <= vok_c[0] && vok_c[1];
		for (int v = 0; v < 2; v++) begin
			den_s3[0][v]     <= DW'(unsigned'(za_c[v]));
			rem_s3[0][2*v]   <= DW'(unsigned'(xa_c[v])) << FRAC_BITS;
			rem_s3[0][2*v+1] <= DW'(unsigned'(ya_c[v])) << FRAC_BITS;
			quo_s3[0][2*v]   <= '0;
			quo_s3[0][2*v+1] <= '0;
		end
	end

	for (genvar k = 0; k < NQ; k++) begin : g_div
		logic [DW-1:0] trial_c [4];

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				trial_c[l] = den_s3[k][l/2] << (NQ - 1 - k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[k+1] <= 1'b0;
			end else begin
				vld_s3[k+1] <= vld_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			ok_s3[k+1]  <= ok_s3[k];
			den_s3[k+1] <= den_s3[k];
			for (int l = 0; l < 4; l++) begin
				if (rem_s3[k][l] >= trial_c[l]) begin
					rem_s3[k+1][l] <= rem_s3[k][l] - trial_c[l];
					quo_s3[k+1][l] <= quo_s3[k][l] | (NQ'(1) << (NQ - 1 - k));
				end else begin
					rem_s3[k+1][l] <= rem_s3[k][l];
					quo_s3[k+1][l] <= quo_s3[k][l];
				end
			end
		end
	end

	assign done     = vld_s3[NQ];
	assign in_view  = ok_s3[NQ];
	assign left_px  = ok_s3[NQ] ? quo_s3[NQ][0][XW-1:0] : '0;
	assign left_py  = ok_s3[NQ] ? quo_s3[NQ][1][YW-1:0] : '0;
	assign right_px = ok_s3[NQ] ? quo_s3[NQ][2][XW-1:0] : '0;
	assign right_py = ok_s3[NQ] ? quo_s3[NQ][3][YW-1:0] : '0;

	`SPP_ASSERT_DLY(a_latency, start && !busy, LAT, done, "Accepted point gave no result on time.")
	`SPP_ASSERT_IMP(a_no_extra, done, $past(start, LAT), "Result without a matching point.")
	`SPP_ASSERT_IMP(a_zero_out, done && !in_view,
		left_px == '0 && left_py == '0 && right_px == '0 && right_py == '0,
		"Coordinates not cleared outside the window.")
	`SPP_ASSERT_IMP(a_in_range, done && in_view,
		(32'(left_px) < 32'(IMAGE_WIDTH*(2**FRAC_BITS)))
		&& (32'(right_px) < 32'(IMAGE_WIDTH*(2**FRAC_BITS))),
		"Column outside the window while in view.")

endmodule
